// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files of the motion and presence detector.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define CSIMP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csimp check failed");

// Next-cycle implication, disabled while reset is low.
`define CSIMP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csimp check failed");

`endif

// ===== rtl/csimp_pkg.sv =====
// Package of the motion and presence detector: sizes, codes, item types, helpers.
// No dependencies; imported by the top, the front and back ends, the checker and the testbench.
package csimp_pkg;

  localparam int MAX_CARRIERS  = 128;
  localparam int RANGE_DEPTH   = 64;
  localparam int HISTORY_DEPTH = 32;

  localparam int CAR_AW   = $clog2(MAX_CARRIERS);
  localparam int CAR_CW   = $clog2(MAX_CARRIERS + 1);
  localparam int HIS_AW   = $clog2(HISTORY_DEPTH);
  localparam int HIS_CW   = $clog2(HISTORY_DEPTH + 1);
  localparam int AMP_W    = 9;
  localparam int NORM_W   = 15;
  localparam int SCALED_W = 16;
  localparam int TOT_W    = $clog2(MAX_CARRIERS * 256 + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_EVAL   = 1'b1;

  localparam logic [1:0] MODE_ABS   = 2'd1;
  localparam logic [1:0] MODE_RANGE = 2'd2;
  localparam logic [1:0] MODE_TRIM  = 2'd3;
  localparam logic [1:0] MODE_NONE  = 2'd0;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_THR     = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BEGIN = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  localparam logic [31:0] THR_ABS     = 32'd8;
  localparam logic [31:0] THR_RANGE   = 32'd150;
  localparam logic [31:0] THR_TRIM    = 32'd250;
  localparam logic [31:0] TIMEOUT_RST = 32'd15000;

  localparam int AMP_SCALE  = 100;
  localparam int BASE_KEEP  = 15;
  localparam int BASE_SHIFT = 4;
  localparam int MIN_TRIM_N = 6;
  localparam int TRIM_RECIP = 205;  // n * 205 >> 10 equals n / 5 for n below 1024
  localparam int TRIM_SHIFT = 10;
  localparam int MIN_RANGE_PKTS = 2;
  localparam int STREAK_MAX = 2;

  typedef struct packed {
    logic              func;
    logic signed [7:0] i_val;
    logic signed [7:0] q_val;
    logic              last;
    logic [31:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic [31:0] score;
    logic        present;
    logic [1:0]  presence_event;
  } out_item_t;

  typedef struct packed {
    logic             is_eval;
    logic             last;
    logic [AMP_W-1:0] amp;
    logic [31:0]      now_ms;
  } op_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] threshold;
    logic [31:0] leave_timeout_ms;
  } cfg_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [AMP_W-1:0] mag8(input logic signed [7:0] x);
    logic [AMP_W-1:0] ext;
    ext = {x[7], x};
    return x[7] ? (AMP_W'(0) - ext) : ext;
  endfunction

endpackage

// ===== rtl/csi_motion_presence_detector_unit.sv =====
// Top level of the Wi-Fi channel-state motion and presence detector.
// Depends on csimp_pkg, csimp_front, csimp_back and assert_macros.svh.
//
//   Channel   Direction  Handshake                        Payload
//   in_       input      in_valid / in_ready              in_item_t (sample or evaluate)
//   out_      output     out_valid / out_ready            out_item_t (score, presence)
//   config    input      psel, penable, pwrite, pready    paddr[3:0], pwdata, prdata
//
// The front end takes one item per cycle into a four-entry queue whenever the queue
// has room; the back end handles a sample in its idle state unless it closes a packet.
// Closing a packet in modes 1 and 3 runs a mean division and then one normalization
// per stored subcarrier on the shared bit-serial divider.
// An evaluate runs at most one division in mode 1, none in mode 2, and in mode 3
// a ranking pass over the m history entries before its division.
// Reset is synchronous and active low; a nonzero mode write clears all scoring state at once.
// A result not taken holds the back end; the queue keeps taking items while it has room.
`include "assert_macros.svh"

module csi_motion_presence_detector_unit
  import csimp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] thr_r, thr_nxt, tmo_r, tmo_nxt;
  logic        wr_en;
  logic        clr;
  cfg_t        cfg;
  logic        q_valid, q_pop;
  op_t         q_item;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // A mode write loads that mode's default threshold and restarts scoring.
  // A mode value of zero is ignored altogether.
  always_comb begin
    mode_nxt = mode_r;
    thr_nxt  = thr_r;
    tmo_nxt  = tmo_r;
    clr      = 1'b0;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_MODE: begin
          if (pwdata[1:0] != MODE_NONE) begin
            mode_nxt = pwdata[1:0];
            clr      = 1'b1;
            unique case (pwdata[1:0])
              MODE_ABS:   thr_nxt = THR_ABS;
              MODE_RANGE: thr_nxt = THR_RANGE;
              default:    thr_nxt = THR_TRIM;
            endcase
          end
        end
        REG_THR:     thr_nxt = pwdata;
        REG_TIMEOUT: tmo_nxt = pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:    prdata = {30'd0, mode_r};
      REG_THR:     prdata = thr_r;
      REG_TIMEOUT: prdata = tmo_r;
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TRIM;
      thr_r  <= THR_TRIM;
      tmo_r  <= TIMEOUT_RST;
    end else begin
      mode_r <= mode_nxt;
      thr_r  <= thr_nxt;
      tmo_r  <= tmo_nxt;
    end
  end

  always_comb begin
    cfg.mode             = mode_r;
    cfg.threshold        = thr_r;
    cfg.leave_timeout_ms = tmo_r;
  end

  // The front end only converts samples to amplitudes and buffers items.
  csimp_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // The back end owns all scoring state, the stores and the result register.
  csimp_back u_back (
    .clk(clk), .rst_n(rst_n), .clr(clr), .cfg(cfg), .q_valid(q_valid),
    .q_item(q_item), .q_pop(q_pop), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );

  // A start event always reports presence, an end event never does.
  `CSIMP_ASSERT_IMP(a_begin_present, clk, rst_n, out_valid && (out_data.presence_event == EV_BEGIN), out_data.present)
  `CSIMP_ASSERT_IMP(a_end_absent, clk, rst_n, out_valid && (out_data.presence_event == EV_END), !out_data.present)
  // The queue can only fill up through an item taken in the cycle before.
  `CSIMP_ASSERT_IMP(a_full_after_push, clk, rst_n, $fell(in_ready), $past(in_valid))
  // A nonzero mode write lands in the mode register.
  `CSIMP_ASSERT_NXT(a_mode_write, clk, rst_n, wr_en && (paddr[3:2] == REG_MODE) && (pwdata[1:0] != MODE_NONE), mode_r == $past(pwdata[1:0]))

endmodule

// ===== rtl/csimp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the amplitude, baseline and history stores.
module csimp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/csimp_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit operands.
// Depends on nothing; shared by every division of the back end.
module csimp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quot
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] rem_sh;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_sh   = {rem_r[31:0], quo_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = 33'd0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== rtl/csimp_front.sv =====
// Front end: accepts items, turns a sample into its amplitude, and queues operations.
// Depends on csimp_pkg.
module csimp_front
  import csimp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output op_t      q_item,
  input  logic     q_pop
);

  op_t                 slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QUEUE_CW-1:0] cnt_r, cnt_nxt;
  logic                push;
  op_t                 op_new;

  assign in_ready = (cnt_r != QUEUE_CW'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = slot_r[rp_r];

  always_comb begin
    op_new.is_eval = (in_data.func == FUNC_EVAL);
    op_new.last    = in_data.last;
    op_new.amp     = mag8(in_data.i_val) + mag8(in_data.q_val);
    op_new.now_ms  = in_data.now_ms;
  end

  always_comb begin
    wp_nxt  = push ? wp_r + QUEUE_AW'(1) : wp_r;
    rp_nxt  = q_pop ? rp_r + QUEUE_AW'(1) : rp_r;
    cnt_nxt = cnt_r + QUEUE_CW'(push) - QUEUE_CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= op_new;
    end
  end

endmodule

// ===== rtl/csimp_back.sv =====
// Back end: packet scoring, evaluation and presence decision, with the result register.
// Depends on csimp_pkg, csimp_ram and csimp_div.
module csimp_back
  import csimp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      clr,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  op_t       q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_MEAN   = 15'b000000000000010,
    ST_RD     = 15'b000000000000100,
    ST_NORM   = 15'b000000000001000,
    ST_NWAIT  = 15'b000000000010000,
    ST_UPD    = 15'b000000000100000,
    ST_PEND   = 15'b000000001000000,
    ST_PDIV   = 15'b000000010000000,
    ST_RI     = 15'b000000100000000,
    ST_LI     = 15'b000001000000000,
    ST_RJ     = 15'b000010000000000,
    ST_CJ     = 15'b000100000000000,
    ST_ACC    = 15'b001000000000000,
    ST_EDIV   = 15'b010000000000000,
    ST_DECIDE = 15'b100000000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [CAR_CW-1:0]   idx_r, idx_nxt, n_r, n_nxt, k_r, k_nxt;
  logic [TOT_W-1:0]    tot_r, tot_nxt;
  logic [31:0]         psum_r, psum_nxt;
  logic [AMP_W-1:0]    mean_r, mean_nxt;
  logic [NORM_W-1:0]   norm_r, norm_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic                ready_r, ready_nxt;
  logic [31:0]         diff_r, diff_nxt, cnt_r, cnt_nxt;
  logic [31:0]         rmax_r, rmax_nxt, rmin_r, rmin_nxt;
  logic [HIS_CW-1:0]   hcnt_r, hcnt_nxt, sn_r, sn_nxt, si_r, si_nxt, sj_r, sj_nxt;
  logic [HIS_CW-1:0]   rank_r, rank_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [31:0]         vi_r, vi_nxt, ssum_r, ssum_nxt, score_r, score_nxt, now_r, now_nxt;
  logic [1:0]          streak_r, streak_nxt;
  logic                pres_r, pres_nxt;
  logic [31:0]         last_r, last_nxt;
  logic                outv_r, outv_nxt;
  out_item_t           outd_r, outd_nxt;

  logic                amp_we, amp_re, base_we, base_re, hist_we, hist_re;
  logic [CAR_AW-1:0]   amp_waddr, car_raddr, base_waddr;
  logic [HIS_AW-1:0]   hist_waddr, hist_raddr;
  logic [AMP_W-1:0]    amp_rd;
  logic [NORM_W-1:0]   base_rd, base_wdata;
  logic [31:0]         hist_rd;
  logic                div_start, div_done;
  logic [31:0]         div_a, div_b, div_q;

  // Sample path helpers.
  logic                stored;
  logic [CAR_CW-1:0]   idx_inc;
  logic [TOT_W-1:0]    tot_inc;
  logic [31:0]         psum_inc;
  // Profile update helpers.
  logic [SCALED_W-1:0] amp_scaled;
  logic [NORM_W-1:0]   dlt;
  logic [2*NORM_W-1:0] dlt_sq;
  logic [NORM_W+5:0]   blend;
  // Trim helpers.
  logic [HIS_CW+7:0]   lo_prod;
  logic [HIS_CW-1:0]   lo_calc;
  // Decision helpers.
  logic                above;
  logic [1:0]          streak_d;
  logic                pres_d;
  logic [1:0]          ev_d;
  logic [31:0]         last_d, elapsed;

  csimp_ram #(.WIDTH(AMP_W), .DEPTH(MAX_CARRIERS)) u_amp (
    .clk(clk), .we(amp_we), .waddr(amp_waddr), .wdata(q_item.amp),
    .re(amp_re), .raddr(car_raddr), .rdata(amp_rd)
  );

  csimp_ram #(.WIDTH(NORM_W), .DEPTH(MAX_CARRIERS)) u_base (
    .clk(clk), .we(base_we), .waddr(base_waddr), .wdata(base_wdata),
    .re(base_re), .raddr(car_raddr), .rdata(base_rd)
  );

  csimp_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(div_q),
    .re(hist_re), .raddr(hist_raddr), .rdata(hist_rd)
  );

  csimp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quot(div_q)
  );

  always_comb begin
    stored     = (idx_r < CAR_CW'(MAX_CARRIERS));
    idx_inc    = stored ? idx_r + CAR_CW'(1) : idx_r;
    tot_inc    = stored ? tot_r + TOT_W'(q_item.amp) : tot_r;
    psum_inc   = sat_add32(psum_r, 32'(q_item.amp));
    amp_scaled = SCALED_W'(amp_rd) * SCALED_W'(AMP_SCALE);
    dlt        = (norm_r > base_rd) ? norm_r - base_rd : base_rd - norm_r;
    dlt_sq     = (2*NORM_W)'(dlt) * (2*NORM_W)'(dlt);
    blend      = (NORM_W+6)'(base_rd) * (NORM_W+6)'(BASE_KEEP) + (NORM_W+6)'(norm_r);
    lo_prod    = (HIS_CW+8)'(hcnt_r) * (HIS_CW+8)'(TRIM_RECIP);
    lo_calc    = (hcnt_r >= HIS_CW'(MIN_TRIM_N)) ? HIS_CW'(lo_prod >> TRIM_SHIFT) : '0;
  end

  // Presence decision on the finished score.
  always_comb begin
    above    = (score_r > cfg.threshold);
    streak_d = above ? ((streak_r < 2'(STREAK_MAX)) ? streak_r + 2'd1 : streak_r) : 2'd0;
    pres_d   = pres_r;
    ev_d     = EV_NONE;
    last_d   = last_r;
    if (above && (streak_d >= 2'(STREAK_MAX))) begin
      last_d = now_r;
      if (!pres_r) begin
        pres_d = 1'b1;
        ev_d   = EV_BEGIN;
      end
    end
    elapsed = (now_r >= last_d) ? now_r - last_d : 32'd0;
    if (pres_d && (elapsed > cfg.leave_timeout_ms)) begin
      pres_d = 1'b0;
      ev_d   = EV_END;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    tot_nxt    = tot_r;
    psum_nxt   = psum_r;
    mean_nxt   = mean_r;
    norm_nxt   = norm_r;
    acc_nxt    = acc_r;
    ready_nxt  = ready_r;
    diff_nxt   = diff_r;
    cnt_nxt    = cnt_r;
    rmax_nxt   = rmax_r;
    rmin_nxt   = rmin_r;
    hcnt_nxt   = hcnt_r;
    sn_nxt     = sn_r;
    si_nxt     = si_r;
    sj_nxt     = sj_r;
    rank_nxt   = rank_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    vi_nxt     = vi_r;
    ssum_nxt   = ssum_r;
    score_nxt  = score_r;
    now_nxt    = now_r;
    streak_nxt = streak_r;
    pres_nxt   = pres_r;
    last_nxt   = last_r;
    outv_nxt   = outv_r && !out_ready;
    outd_nxt   = outd_r;
    q_pop      = 1'b0;
    amp_we     = 1'b0;
    amp_re     = 1'b0;
    base_we    = 1'b0;
    base_re    = 1'b0;
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    amp_waddr  = idx_r[CAR_AW-1:0];
    car_raddr  = k_r[CAR_AW-1:0];
    base_waddr = k_r[CAR_AW-1:0];
    base_wdata = norm_r;
    hist_waddr = hcnt_r[HIS_AW-1:0];
    hist_raddr = si_r[HIS_AW-1:0];
    div_start  = 1'b0;
    div_a      = acc_r;
    div_b      = 32'(n_r);

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_item.is_eval) begin
            amp_we   = stored;
            idx_nxt  = idx_inc;
            tot_nxt  = tot_inc;
            psum_nxt = psum_inc;
            if (q_item.last) begin
              idx_nxt  = '0;
              tot_nxt  = '0;
              psum_nxt = '0;
              if (cfg.mode == MODE_RANGE) begin
                if (cnt_r < 32'(RANGE_DEPTH)) begin
                  cnt_nxt = cnt_r + 32'd1;
                  if (psum_inc > rmax_r) rmax_nxt = psum_inc;
                  if (psum_inc < rmin_r) rmin_nxt = psum_inc;
                end
              end else if (idx_inc != '0) begin
                n_nxt     = idx_inc;
                div_start = 1'b1;
                div_a     = 32'(tot_inc);
                div_b     = 32'(idx_inc);
                state_nxt = ST_MEAN;
              end
            end
          end else begin
            now_nxt = q_item.now_ms;
            if (cfg.mode == MODE_ABS) begin
              diff_nxt = '0;
              cnt_nxt  = '0;
              if (cnt_r != '0) begin
                div_start = 1'b1;
                div_a     = diff_r;
                div_b     = cnt_r;
                state_nxt = ST_EDIV;
              end else begin
                score_nxt = '0;
                state_nxt = ST_DECIDE;
              end
            end else if (cfg.mode == MODE_RANGE) begin
              score_nxt = (cnt_r > 32'(MIN_RANGE_PKTS)) ? rmax_r - rmin_r : 32'd0;
              cnt_nxt   = '0;
              rmax_nxt  = '0;
              rmin_nxt  = '1;
              state_nxt = ST_DECIDE;
            end else begin
              hcnt_nxt = '0;
              sn_nxt   = hcnt_r;
              lo_nxt   = lo_calc;
              hi_nxt   = hcnt_r - lo_calc;
              si_nxt   = '0;
              ssum_nxt = '0;
              if (hcnt_r == '0) begin
                score_nxt = '0;
                state_nxt = ST_DECIDE;
              end else begin
                state_nxt = ST_RI;
              end
            end
          end
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          if (div_q == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            mean_nxt  = div_q[AMP_W-1:0];
            k_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        amp_re    = 1'b1;
        base_re   = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        div_start = 1'b1;
        div_a     = 32'(amp_scaled);
        div_b     = 32'(mean_r);
        state_nxt = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (div_done) begin
          norm_nxt  = div_q[NORM_W-1:0];
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        base_we = 1'b1;
        if (ready_r) begin
          base_wdata = NORM_W'(blend >> BASE_SHIFT);
          acc_nxt    = sat_add32(acc_r,
                         (cfg.mode == MODE_ABS) ? 32'(dlt) : 32'(dlt_sq));
        end
        k_nxt     = k_r + CAR_CW'(1);
        state_nxt = (k_nxt == n_r) ? ST_PEND : ST_RD;
      end
      ST_PEND: begin
        if (!ready_r) begin
          ready_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else if ((cfg.mode == MODE_ABS) || (hcnt_r < HIS_CW'(HISTORY_DEPTH))) begin
          div_start = 1'b1;
          state_nxt = ST_PDIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PDIV: begin
        if (div_done) begin
          if (cfg.mode == MODE_ABS) begin
            diff_nxt = sat_add32(diff_r, div_q);
            cnt_nxt  = sat_add32(cnt_r, 32'd1);
          end else begin
            hist_we  = 1'b1;
            hcnt_nxt = hcnt_r + HIS_CW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_RI: begin
        hist_re   = 1'b1;
        state_nxt = ST_LI;
      end
      ST_LI: begin
        vi_nxt    = hist_rd;
        sj_nxt    = '0;
        rank_nxt  = '0;
        state_nxt = ST_RJ;
      end
      ST_RJ: begin
        hist_re    = 1'b1;
        hist_raddr = sj_r[HIS_AW-1:0];
        state_nxt  = ST_CJ;
      end
      ST_CJ: begin
        // Stable rank: equal values count as smaller when they sit earlier.
        if ((hist_rd < vi_r) || ((hist_rd == vi_r) && (sj_r < si_r))) begin
          rank_nxt = rank_r + HIS_CW'(1);
        end
        sj_nxt    = sj_r + HIS_CW'(1);
        state_nxt = (sj_nxt == sn_r) ? ST_ACC : ST_RJ;
      end
      ST_ACC: begin
        if ((rank_r >= lo_r) && (rank_r < hi_r)) begin
          ssum_nxt = sat_add32(ssum_r, vi_r);
        end
        si_nxt = si_r + HIS_CW'(1);
        if (si_nxt == sn_r) begin
          div_start = 1'b1;
          div_a     = ssum_nxt;
          div_b     = 32'(hi_r - lo_r);
          state_nxt = ST_EDIV;
        end else begin
          state_nxt = ST_RI;
        end
      end
      ST_EDIV: begin
        if (div_done) begin
          score_nxt = div_q;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!outv_r || out_ready) begin
          outv_nxt                = 1'b1;
          outd_nxt.score          = score_r;
          outd_nxt.present        = pres_d;
          outd_nxt.presence_event = ev_d;
          streak_nxt              = streak_d;
          pres_nxt                = pres_d;
          last_nxt                = last_d;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      tot_r    <= '0;
      psum_r   <= '0;
      ready_r  <= 1'b0;
      diff_r   <= '0;
      cnt_r    <= '0;
      rmax_r   <= '0;
      rmin_r   <= '1;
      hcnt_r   <= '0;
      streak_r <= '0;
      pres_r   <= 1'b0;
      last_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      tot_r    <= tot_nxt;
      psum_r   <= psum_nxt;
      ready_r  <= ready_nxt;
      diff_r   <= diff_nxt;
      cnt_r    <= cnt_nxt;
      rmax_r   <= rmax_nxt;
      rmin_r   <= rmin_nxt;
      hcnt_r   <= hcnt_nxt;
      streak_r <= streak_nxt;
      pres_r   <= pres_nxt;
      last_r   <= last_nxt;
    end
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else begin
      outv_r <= outv_nxt;
    end
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    mean_r  <= mean_nxt;
    norm_r  <= norm_nxt;
    acc_r   <= acc_nxt;
    sn_r    <= sn_nxt;
    si_r    <= si_nxt;
    sj_r    <= sj_nxt;
    rank_r  <= rank_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    vi_r    <= vi_nxt;
    ssum_r  <= ssum_nxt;
    score_r <= score_nxt;
    now_r   <= now_nxt;
    outd_r  <= outd_nxt;
  end

  assign out_valid = outv_r;
  assign out_data  = outd_r;

endmodule

// ===== sim/csimp_score_checker.sv =====
// Scoring checker for the motion and presence detector: watches the item channels and
// the register port, predicts every score result and compares it. Depends on csimp_pkg.
`timescale 1ns / 1ps

module csimp_score_checker
  import csimp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          scores_waiting,
  output int          scores_seen,
  output int          packets_closed
);

  logic [1:0]  mdl_mode;
  logic [31:0] mdl_thr;
  logic [31:0] mdl_timeout;
  logic [31:0] amp_mem [MAX_CARRIERS];
  logic [31:0] base_mem [MAX_CARRIERS];
  logic        base_ready;
  logic [31:0] car_idx;
  logic [31:0] pkt_sum;
  logic [31:0] diff_acc;
  logic [31:0] pkt_cnt;
  logic [31:0] hist [HISTORY_DEPTH];
  logic [31:0] hist_cnt;
  logic [31:0] rng_max;
  logic [31:0] rng_min;
  logic [1:0]  streak;
  logic        present_q;
  logic [31:0] active_ms;
  out_item_t   score_q[$];

  function automatic logic [31:0] sadd(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] amp_of(input logic [7:0] v);
    return v[7] ? 32'd256 - {24'd0, v} : {24'd0, v};
  endfunction

  task automatic clear_scoring();
    base_ready = 1'b0;
    car_idx    = 0;
    pkt_sum    = 0;
    diff_acc   = 0;
    pkt_cnt    = 0;
    hist_cnt   = 0;
    rng_max    = 0;
    rng_min    = 32'hFFFF_FFFF;
    streak     = 0;
    present_q  = 1'b0;
    active_ms  = 0;
    for (int k = 0; k < HISTORY_DEPTH; k++) hist[k] = 0;
  endtask

  // Normalizes the stored profile by its mean and compares it with the running baseline.
  task automatic score_profile(input bit squared);
    logic [31:0] n, total, mean, norm, b;
    logic [63:0] acc, d;
    n = car_idx;
    total = 0;
    acc = 0;
    if (n == 0) return;
    for (int k = 0; k < n; k++) total += amp_mem[k];
    mean = total / n;
    if (mean == 0) return;
    for (int k = 0; k < n; k++) begin
      norm = (amp_mem[k] * 32'd100) / mean;
      if (!base_ready) begin
        base_mem[k] = norm;
      end else begin
        b = base_mem[k];
        d = norm > b ? 64'(norm - b) : 64'(b - norm);
        acc += squared ? d * d : d;
        base_mem[k] = (b * 32'd15 + norm) / 32'd16;
      end
    end
    if (!base_ready) begin
      base_ready = 1'b1;
      return;
    end
    if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    if (squared) begin
      if (hist_cnt < HISTORY_DEPTH) begin
        hist[hist_cnt] = acc[31:0] / n;
        hist_cnt++;
      end
    end else begin
      diff_acc = sadd(diff_acc, acc[31:0] / n);
      pkt_cnt  = sadd(pkt_cnt, 32'd1);
    end
  endtask

  function automatic logic [31:0] window_score();
    logic [31:0] sc, n, lo, hi, v, tmp [HISTORY_DEPTH];
    logic [63:0] sum;
    int j;
    sc = 0;
    if (mdl_mode == MODE_ABS) begin
      if (pkt_cnt > 0) sc = diff_acc / pkt_cnt;
      diff_acc = 0;
      pkt_cnt  = 0;
    end else if (mdl_mode == MODE_RANGE) begin
      if (pkt_cnt > 2) sc = rng_max - rng_min;
      pkt_cnt = 0;
      rng_max = 0;
      rng_min = 32'hFFFF_FFFF;
    end else begin
      n = hist_cnt > HISTORY_DEPTH ? HISTORY_DEPTH : hist_cnt;
      hist_cnt = 0;
      if (n == 0) return 0;
      tmp = hist;
      for (int i = 1; i < n; i++) begin
        v = tmp[i];
        j = i;
        while (j > 0 && tmp[j-1] > v) begin
          tmp[j] = tmp[j-1];
          j--;
        end
        tmp[j] = v;
      end
      lo = 0;
      hi = n;
      if (n >= 6) begin
        lo = n / 5;
        hi = n - lo;
      end
      sum = 0;
      for (int i = lo; i < hi; i++) sum += tmp[i];
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      sc = sum[31:0] / (hi - lo);
    end
    return sc;
  endfunction

  task automatic take_item(input in_item_t it);
    logic [31:0] amp, elapsed;
    out_item_t   r;
    if (it.func == FUNC_SAMPLE) begin
      amp = amp_of(it.i_val) + amp_of(it.q_val);
      if (car_idx < MAX_CARRIERS) begin
        amp_mem[car_idx] = amp;
        car_idx++;
      end
      pkt_sum = sadd(pkt_sum, amp);
      if (it.last) begin
        packets_closed++;
        if (mdl_mode == MODE_ABS) begin
          score_profile(1'b0);
        end else if (mdl_mode == MODE_RANGE) begin
          if (pkt_cnt < RANGE_DEPTH) begin
            pkt_cnt++;
            if (pkt_sum > rng_max) rng_max = pkt_sum;
            if (pkt_sum < rng_min) rng_min = pkt_sum;
          end
        end else begin
          score_profile(1'b1);
        end
        car_idx = 0;
        pkt_sum = 0;
      end
    end else begin
      r.score = window_score();
      r.presence_event = EV_NONE;
      if (r.score > mdl_thr) begin
        if (streak < 2) streak++;
        if (streak >= 2) begin
          active_ms = it.now_ms;
          if (!present_q) begin
            present_q = 1'b1;
            r.presence_event = EV_BEGIN;
          end
        end
      end else begin
        streak = 0;
      end
      if (present_q) begin
        elapsed = it.now_ms >= active_ms ? it.now_ms - active_ms : 0;
        if (elapsed > mdl_timeout) begin
          present_q = 1'b0;
          r.presence_event = EV_END;
        end
      end
      r.present = present_q;
      score_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("[%0t] score check: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    scores_seen = 0;
    packets_closed = 0;
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      mdl_mode    = MODE_TRIM;
      mdl_thr     = THR_TRIM;
      mdl_timeout = TIMEOUT_RST;
      for (int k = 0; k < MAX_CARRIERS; k++) begin
        amp_mem[k]  = 0;
        base_mem[k] = 0;
      end
      clear_scoring();
      score_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE: begin
            if (pwdata[1:0] != MODE_NONE) begin
              mdl_mode = pwdata[1:0];
              mdl_thr  = mdl_mode == MODE_ABS ? THR_ABS :
                         mdl_mode == MODE_RANGE ? THR_RANGE : THR_TRIM;
              clear_scoring();
            end
          end
          REG_THR:     mdl_thr = pwdata;
          REG_TIMEOUT: mdl_timeout = pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) take_item(in_data);
      if (out_valid && out_ready) begin
        scores_seen++;
        if (score_q.size() == 0) begin
          report_mismatch("unexpected result, score", 0, out_data.score);
        end else begin
          exp_r = score_q.pop_front();
          if (out_data.score !== exp_r.score)
            report_mismatch("score", exp_r.score, out_data.score);
          if (out_data.present !== exp_r.present)
            report_mismatch("present", exp_r.present, out_data.present);
          if (out_data.presence_event !== exp_r.presence_event)
            report_mismatch("presence_event", exp_r.presence_event, out_data.presence_event);
        end
      end
    end
    scores_waiting = score_q.size();
  end

endmodule

// ===== sim/csi_motion_presence_detector_unit_test.sv =====
// Testbench top of the motion and presence detector: clock, reset, register writes,
// packet stimulus and the verdict. Depends on csimp_pkg and csimp_score_checker.
`timescale 1ns / 1ps

module csi_motion_presence_detector_unit_test;
  import csimp_pkg::*;

  // The watchdog trips after this many cycles with no handshake of any kind. The
  // slowest legal step is a packet close with all carriers stored, queued behind a
  // full mode 3 ranking pass, plus a long receiver hold-off.
  localparam int STALL_LIMIT = 40000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          scores_waiting;
  int          scores_seen;
  int          packets_closed;
  int          items_sent;
  logic [31:0] clock_ms;
  bit          no_idle;
  bit          hold_req;
  int          quiet_cycles;

  csi_motion_presence_detector_unit u_top (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  csimp_score_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .scores_waiting, .scores_seen, .packets_closed
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls about one cycle in nine unless no_idle is set. When a hold-off is requested it
  // refuses results for one long stretch so the internal queue fills and in_ready drops.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 600;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || $urandom_range(99) >= 11;
      end
    end
  end

  // Watchdog: counts cycles in which neither channel nor the register port moves.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
        quiet_cycles = 0;
      else if (rst_n)
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("csi_motion_presence_detector_unit_test NOT OK");
        $finish;
      end
    end
  end

  // Offers one item and holds it until the block takes it; then maybe idles.
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!no_idle && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_sample(input logic [7:0] i_v, input logic [7:0] q_v, input bit last);
    in_item_t it;
    it.func   = FUNC_SAMPLE;
    it.i_val  = i_v;
    it.q_val  = q_v;
    it.last   = last;
    it.now_ms = $urandom;
    send_item(it);
  endtask

  task automatic send_eval(input logic [31:0] now);
    in_item_t it;
    it.func   = FUNC_EVAL;
    it.i_val  = $urandom;
    it.q_val  = $urandom;
    it.last   = $urandom;
    it.now_ms = now;
    send_item(it);
  endtask

  // A packet of n subcarriers. A dead packet carries only zero I/Q, so its mean is zero.
  task automatic send_packet(input int n, input bit dead);
    for (int k = 0; k < n; k++)
      send_sample(dead ? 8'd0 : 8'($urandom), dead ? 8'd0 : 8'($urandom), k == n - 1);
  endtask

  // Lets the block drain before a register write. Every phase ends on an evaluate,
  // so once its score has arrived the back end has nothing left in flight.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (scores_waiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Time mostly moves forward in packet-sized steps, with the odd jump back or
  // a fully random stamp so every bit of now_ms gets exercised.
  function automatic logic [31:0] next_ms();
    int pick;
    pick = $urandom_range(99);
    if (pick < 4)
      clock_ms = $urandom;
    else if (pick < 9)
      clock_ms = clock_ms - $urandom_range(1, 4000);
    else
      clock_ms = clock_ms + $urandom_range(0, 3000);
    return clock_ms;
  endfunction

  // Random traffic: mostly short well-formed packets, a few long ones (some past the
  // carrier limit), some dead packets, and evaluates at a rate chosen per phase.
  task automatic run_traffic(input int budget, input int eval_pct);
    int stop_at, pick;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 85)
        send_packet($urandom_range(1, 12), $urandom_range(99) < 4);
      else if (pick < 97)
        send_packet($urandom_range(13, 40), 1'b0);
      else
        send_packet($urandom_range(100, 140), 1'b0);
      if ($urandom_range(99) < eval_pct) send_eval(next_ms());
      if ($urandom_range(99) < 3) send_eval(next_ms());
    end
    send_eval(next_ms());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    items_sent = 0;
    clock_ms  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part in the reset mode. The first packet is full width so every
    // baseline entry is written before any shorter or longer packet reads it.
    for (int k = 0; k < MAX_CARRIERS; k++)
      send_sample(k == 0 ? 8'h80 : k == 1 ? 8'h7F : 8'($urandom),
                  k == 2 ? 8'h80 : k == 3 ? 8'h7F : 8'($urandom), k == MAX_CARRIERS - 1);
    send_eval(32'd0);
    send_packet(3, 1'b1);
    send_sample(8'h7F, 8'h80, 1'b0);
    send_sample(8'h00, 8'h00, 1'b0);
    send_sample(8'h80, 8'h7F, 1'b1);
    send_packet(5, 1'b0);
    send_eval(32'hFFFF_FFFF);
    send_eval(32'd5);
    run_traffic(250, 20);
    settle();

    // Absolute-difference scoring, any nonzero score counts as motion and presence ends at
    // once. The receiver holds off mid-phase so the block backs up.
    write_reg(REG_MODE, {30'd0, MODE_ABS});
    write_reg(REG_THR, 32'd0);
    write_reg(REG_TIMEOUT, 32'd0);
    run_traffic(150, 30);
    hold_req = 1'b1;
    run_traffic(150, 60);
    hold_req = 1'b0;
    settle();

    // Amplitude range; windows need more than two packets to score.
    write_reg(REG_MODE, {30'd0, MODE_RANGE});
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    run_traffic(300, 12);
    settle();

    // A zero mode write is ignored; an unreachable threshold keeps presence away.
    write_reg(REG_MODE, {30'd0, MODE_NONE});
    write_reg(REG_THR, 32'hFFFF_FFFF);
    run_traffic(150, 15);
    settle();

    // Default mode 1 threshold with a short timeout, no idling on either side.
    no_idle = 1'b1;
    write_reg(REG_MODE, {30'd0, MODE_ABS});
    write_reg(REG_TIMEOUT, 32'd2000);
    run_traffic(250, 25);
    no_idle = 1'b0;
    settle();

    // Trimmed squared difference with a history that fills past its depth.
    write_reg(REG_MODE, {30'd0, MODE_TRIM});
    write_reg(REG_THR, 32'd100);
    write_reg(REG_TIMEOUT, 32'd5000);
    run_traffic(350, 3);
    settle();

    $display("run covered %0d items, %0d closed packets and %0d scores in all three modes",
             items_sent, packets_closed, scores_seen);
    if (fail_count == 0) begin
      $display("csi_motion_presence_detector_unit_test OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("csi_motion_presence_detector_unit_test NOT OK");
    end
    $finish;
  end

endmodule
